@@ hw/rtl/rsi_pkg.sv @@
// Shared types, constants and microprogram for the RSI block.
package rsi_pkg;

  // Field and register widths, RSI full scale and period reset value
  localparam int CLOSE_W        = 32;
  localparam int PERIOD_W       = 10;
  localparam int RSI_W          = 15;
  localparam int FRAC_EXTRA     = 16;
  localparam int RSI_Q_W        = 15;
  localparam int RSI_FULL       = 25600;
  localparam int PERIOD_RESET   = 14;
  localparam int PRICE_BITS_DEF = 32;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_PERIOD = 1'b0;

  // Microprogram steps
  localparam int STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t ST_ACCEPT   = 5'd0;
  localparam step_t ST_MOVE     = 5'd1;
  localparam step_t ST_BRANCH   = 5'd2;
  localparam step_t ST_ACC      = 5'd3;
  localparam step_t ST_DSUM_G   = 5'd4;
  localparam step_t ST_WSUM_G   = 5'd5;
  localparam step_t ST_SSUM_G   = 5'd6;
  localparam step_t ST_DSUM_L   = 5'd7;
  localparam step_t ST_WSUM_L   = 5'd8;
  localparam step_t ST_SSUM_L   = 5'd9;
  localparam step_t ST_MUL_G    = 5'd10;
  localparam step_t ST_DMUL_G   = 5'd11;
  localparam step_t ST_WMUL_G   = 5'd12;
  localparam step_t ST_SMUL_G   = 5'd13;
  localparam step_t ST_MUL_L    = 5'd14;
  localparam step_t ST_DMUL_L   = 5'd15;
  localparam step_t ST_WMUL_L   = 5'd16;
  localparam step_t ST_SMUL_L   = 5'd17;
  localparam step_t ST_MUL_RSI  = 5'd18;
  localparam step_t ST_DIV_RSI  = 5'd19;
  localparam step_t ST_WAIT_RSI = 5'd20;
  localparam step_t ST_EMIT     = 5'd21;
  localparam step_t ST_DONE     = 5'd22;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_MOVE,
    OP_ACC,
    OP_DIV_SUM_G,
    OP_DIV_SUM_L,
    OP_STORE_G,
    OP_STORE_L,
    OP_MUL_G,
    OP_MUL_L,
    OP_DIV_MUL_G,
    OP_DIV_MUL_L,
    OP_MUL_RSI,
    OP_DIV_RSI,
    OP_EMIT
  } op_t;

  // Jump conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_FIRST,
    C_SMOOTH,
    C_WARM_MORE,
    C_DIV_BUSY,
    C_LOSS_ZERO,
    C_OUT_FULL
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } uword_t;

  // Status flags from datapath to sequencer
  typedef struct packed {
    logic in_taken;
    logic first;
    logic smooth;
    logic warm_more;
    logic div_busy;
    logic loss_zero;
    logic out_full;
  } stat_t;

  function automatic uword_t uw(op_t op, cond_t cond, step_t target);
    uword_t w;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  // Control store: one word per step
  function automatic uword_t ucode(step_t step);
    uword_t w;
    case (step)
      ST_ACCEPT:   w = uw(OP_ACCEPT,    C_NO_INPUT,  ST_ACCEPT);
      ST_MOVE:     w = uw(OP_MOVE,      C_FIRST,     ST_ACCEPT);
      ST_BRANCH:   w = uw(OP_NOP,       C_SMOOTH,    ST_MUL_G);
      ST_ACC:      w = uw(OP_ACC,       C_WARM_MORE, ST_ACCEPT);
      ST_DSUM_G:   w = uw(OP_DIV_SUM_G, C_NEVER,     ST_ACCEPT);
      ST_WSUM_G:   w = uw(OP_NOP,       C_DIV_BUSY,  ST_WSUM_G);
      ST_SSUM_G:   w = uw(OP_STORE_G,   C_NEVER,     ST_ACCEPT);
      ST_DSUM_L:   w = uw(OP_DIV_SUM_L, C_NEVER,     ST_ACCEPT);
      ST_WSUM_L:   w = uw(OP_NOP,       C_DIV_BUSY,  ST_WSUM_L);
      ST_SSUM_L:   w = uw(OP_STORE_L,   C_ALWAYS,    ST_MUL_RSI);
      ST_MUL_G:    w = uw(OP_MUL_G,     C_NEVER,     ST_ACCEPT);
      ST_DMUL_G:   w = uw(OP_DIV_MUL_G, C_NEVER,     ST_ACCEPT);
      ST_WMUL_G:   w = uw(OP_NOP,       C_DIV_BUSY,  ST_WMUL_G);
      ST_SMUL_G:   w = uw(OP_STORE_G,   C_NEVER,     ST_ACCEPT);
      ST_MUL_L:    w = uw(OP_MUL_L,     C_NEVER,     ST_ACCEPT);
      ST_DMUL_L:   w = uw(OP_DIV_MUL_L, C_NEVER,     ST_ACCEPT);
      ST_WMUL_L:   w = uw(OP_NOP,       C_DIV_BUSY,  ST_WMUL_L);
      ST_SMUL_L:   w = uw(OP_STORE_L,   C_NEVER,     ST_ACCEPT);
      ST_MUL_RSI:  w = uw(OP_MUL_RSI,   C_LOSS_ZERO, ST_EMIT);
      ST_DIV_RSI:  w = uw(OP_DIV_RSI,   C_NEVER,     ST_ACCEPT);
      ST_WAIT_RSI: w = uw(OP_NOP,       C_DIV_BUSY,  ST_WAIT_RSI);
      ST_EMIT:     w = uw(OP_EMIT,      C_OUT_FULL,  ST_EMIT);
      ST_DONE:     w = uw(OP_NOP,       C_ALWAYS,    ST_ACCEPT);
      default:     w = uw(OP_NOP,       C_ALWAYS,    ST_ACCEPT);
    endcase
    return w;
  endfunction

endpackage

@@ hw/rtl/rsi_if.sv @@
// Valid/ready channel interfaces for price requests and RSI results.
interface rsi_in_if;
  import rsi_pkg::*;
  logic               valid;
  logic               ready;
  logic [CLOSE_W-1:0] close_price;
  logic               new_series;

  modport source (output valid, output close_price, output new_series, input ready);
  modport sink   (input valid, input close_price, input new_series, output ready);
endinterface

interface rsi_out_if;
  import rsi_pkg::*;
  logic             valid;
  logic             ready;
  logic [RSI_W-1:0] rsi_value;

  modport source (output valid, output rsi_value, input ready);
  modport sink   (input valid, input rsi_value, output ready);
endinterface

@@ hw/rtl/relative_strength_index.sv @@
// Wilder RSI over a stream of Q16.16 closing prices, microcoded around one serial divider.
// One price request at a time: a first price only records the close; other warm-up moves add to sums.
// A result move runs the serial divider for the gain and the loss average (sums on the closing warm-up
//   move, smoothing after it), then for the RSI, skipped when the loss average is zero.
// The output register lets the next price in; the emit step waits while it still holds a result.
// Reset (synchronous, rst_n low): period back to 14, series and averages cleared, no result held.
module relative_strength_index #(
  parameter int PRICE_BITS = rsi_pkg::PRICE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  rsi_in_if.sink                           in_ch,
  rsi_out_if.source                        out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rsi_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [rsi_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [rsi_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import rsi_pkg::*;

  stat_t               stat;
  op_t                 op;
  logic                period_we;
  logic [PERIOD_W-1:0] period;

  // Register access: one register, written in the access phase
  assign pready    = 1'b1;
  assign period_we = psel && penable && pwrite && pready && (paddr[2] == REG_PERIOD);
  assign prdata    = (paddr[2] == REG_PERIOD) ? CFG_DATA_W'(period) : '0;

  rsi_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .op    (op)
  );

  rsi_dp #(
    .PRICE_BITS (PRICE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .op             (op),
    .stat           (stat),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_close_price (in_ch.close_price),
    .in_new_series  (in_ch.new_series),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_rsi_value  (out_ch.rsi_value),
    .period_we      (period_we),
    .period_wdata   (pwdata[PERIOD_W-1:0]),
    .period         (period)
  );

endmodule

@@ hw/rtl/rsi_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
module rsi_div #(
  parameter int PRICE_BITS = rsi_pkg::PRICE_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic [$clog2(((PRICE_BITS < rsi_pkg::CLOSE_W) ? PRICE_BITS : rsi_pkg::CLOSE_W)
                + rsi_pkg::FRAC_EXTRA + 1)-1:0] iters,
  input  logic [((PRICE_BITS < rsi_pkg::CLOSE_W) ? PRICE_BITS : rsi_pkg::CLOSE_W)
                + rsi_pkg::FRAC_EXTRA:0] rem_init,
  input  logic [((PRICE_BITS < rsi_pkg::CLOSE_W) ? PRICE_BITS : rsi_pkg::CLOSE_W)
                + rsi_pkg::FRAC_EXTRA-1:0] dividend_lo,
  input  logic [((PRICE_BITS < rsi_pkg::CLOSE_W) ? PRICE_BITS : rsi_pkg::CLOSE_W)
                + rsi_pkg::FRAC_EXTRA:0] divisor,
  output logic busy,
  output logic [((PRICE_BITS < rsi_pkg::CLOSE_W) ? PRICE_BITS : rsi_pkg::CLOSE_W)
                + rsi_pkg::FRAC_EXTRA-1:0] quotient
);
  import rsi_pkg::*;

  localparam int PW    = (PRICE_BITS < CLOSE_W) ? PRICE_BITS : CLOSE_W;
  localparam int ACC_W = PW + FRAC_EXTRA;
  localparam int DEN_W = ACC_W + 1;
  localparam int CNT_W = $clog2(ACC_W + 1);

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [ACC_W-1:0] q_r, q_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  // One restoring step: bring down the next dividend bit and try the subtract
  always_comb begin
    trial = {rem_r, q_r[ACC_W-1]};
    diff  = trial - {1'b0, den_r};
    fits  = (trial >= {1'b0, den_r});
  end

  always_comb begin
    rem_nxt = rem_r;
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    if (start) begin
      rem_nxt = rem_init;
      q_nxt   = dividend_lo;
      cnt_nxt = iters;
    end else if (cnt_r != '0) begin
      rem_nxt = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      q_nxt   = {q_r[ACC_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    if (start) begin
      den_r <= divisor;
    end
  end

  assign busy     = (cnt_r != '0);
  assign quotient = q_r;

endmodule

@@ hw/rtl/rsi_seq.sv @@
// Microcode sequencer: step counter, control store fetch and jump logic.
module rsi_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  rsi_pkg::stat_t stat,
  output rsi_pkg::op_t   op
);
  import rsi_pkg::*;

  step_t  upc_r, upc_nxt;
  uword_t word;
  logic   jump;

  assign word = ucode(upc_r);
  assign op   = word.op;

  // Jump condition select
  always_comb begin
    case (word.cond)
      C_NEVER:     jump = 1'b0;
      C_ALWAYS:    jump = 1'b1;
      C_NO_INPUT:  jump = !stat.in_taken;
      C_FIRST:     jump = stat.first;
      C_SMOOTH:    jump = stat.smooth;
      C_WARM_MORE: jump = stat.warm_more;
      C_DIV_BUSY:  jump = stat.div_busy;
      C_LOSS_ZERO: jump = stat.loss_zero;
      C_OUT_FULL:  jump = stat.out_full;
      default:     jump = 1'b1;
    endcase
  end

  always_comb begin
    upc_nxt = jump ? word.target : upc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= ST_ACCEPT;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

@@ hw/rtl/rsi_dp.sv @@
// RSI datapath: series state, averages, multiplier, divider loads and output register.
module rsi_dp #(
  parameter int PRICE_BITS = rsi_pkg::PRICE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rsi_pkg::op_t                      op,
  output rsi_pkg::stat_t                    stat,
  // price requests
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rsi_pkg::CLOSE_W-1:0]       in_close_price,
  input  logic                              in_new_series,
  // results
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rsi_pkg::RSI_W-1:0]         out_rsi_value,
  // register file
  input  logic                              period_we,
  input  logic [rsi_pkg::PERIOD_W-1:0]      period_wdata,
  output logic [rsi_pkg::PERIOD_W-1:0]      period
);
  import rsi_pkg::*;

  localparam int PW    = (PRICE_BITS < CLOSE_W) ? PRICE_BITS : CLOSE_W;
  localparam int ACC_W = PW + FRAC_EXTRA;
  localparam int DEN_W = ACC_W + 1;
  localparam int NUM_W = ACC_W + RSI_Q_W;
  localparam int CNT_W = $clog2(ACC_W + 1);

  logic [PERIOD_W-1:0] period_r;
  logic [PW-1:0]       price_r;
  logic                start_r;
  logic [PW-1:0]       prev_r;
  logic                have_r;
  logic [PW-1:0]       move_r;
  logic                up_r;
  logic [PERIOD_W-1:0] moves_r;
  logic [ACC_W-1:0]    gavg_r;
  logic [ACC_W-1:0]    lavg_r;
  logic [NUM_W-1:0]    mul_r;
  logic                out_valid_r;
  logic [RSI_W-1:0]    out_rsi_r;

  logic [PERIOD_W-1:0] p_eff;
  logic [PERIOD_W-1:0] p_less;
  logic [PW-1:0]       gmove;
  logic [PW-1:0]       lmove;
  logic                first;
  logic                out_full;
  logic                in_taken;
  logic [NUM_W-1:0]    smooth_num;
  logic [RSI_W-1:0]    rsi_special;

  logic                div_start;
  logic [CNT_W-1:0]    div_iters;
  logic [DEN_W-1:0]    div_rem;
  logic [ACC_W-1:0]    div_lo;
  logic [DEN_W-1:0]    div_den;
  logic                div_busy;
  logic [ACC_W-1:0]    div_q;

  // A zero period behaves as one
  assign p_eff  = (period_r == '0) ? PERIOD_W'(1) : period_r;
  assign p_less = p_eff - 1'b1;

  assign gmove    = up_r ? move_r : '0;
  assign lmove    = up_r ? '0 : move_r;
  assign first    = start_r || !have_r;
  assign out_full = out_valid_r && !out_ready;
  assign in_ready = (op == OP_ACCEPT);
  assign in_taken = in_valid && in_ready;

  // Status back to the sequencer
  always_comb begin
    stat.in_taken  = in_taken;
    stat.first     = first;
    stat.smooth    = (moves_r >= p_eff);
    stat.warm_more = ({1'b0, moves_r} + 1'b1) < {1'b0, p_eff};
    stat.div_busy  = div_busy;
    stat.loss_zero = (lavg_r == '0);
    stat.out_full  = out_full;
  end

  // Numerator of a smoothing step: avg*(period-1) + move scaled up
  always_comb begin
    if (op == OP_DIV_MUL_G) begin
      smooth_num = mul_r + NUM_W'({gmove, {FRAC_EXTRA{1'b0}}});
    end else begin
      smooth_num = mul_r + NUM_W'({lmove, {FRAC_EXTRA{1'b0}}});
    end
  end

  // Divider loads; the top part of each dividend is already below the divisor
  always_comb begin
    div_start = 1'b0;
    div_iters = CNT_W'(ACC_W);
    div_rem   = DEN_W'(gavg_r[ACC_W-1:PW]);
    div_lo    = {gavg_r[PW-1:0], {FRAC_EXTRA{1'b0}}};
    div_den   = DEN_W'(p_eff);
    case (op)
      OP_DIV_SUM_G: begin
        div_start = 1'b1;
      end
      OP_DIV_SUM_L: begin
        div_start = 1'b1;
        div_rem   = DEN_W'(lavg_r[ACC_W-1:PW]);
        div_lo    = {lavg_r[PW-1:0], {FRAC_EXTRA{1'b0}}};
      end
      OP_DIV_MUL_G, OP_DIV_MUL_L: begin
        div_start = 1'b1;
        div_rem   = DEN_W'(smooth_num[NUM_W-1:ACC_W]);
        div_lo    = smooth_num[ACC_W-1:0];
      end
      OP_DIV_RSI: begin
        div_start = 1'b1;
        div_iters = CNT_W'(RSI_Q_W);
        div_rem   = DEN_W'(mul_r[NUM_W-1:RSI_Q_W]);
        div_lo    = {mul_r[RSI_Q_W-1:0], {(ACC_W-RSI_Q_W){1'b0}}};
        div_den   = DEN_W'(gavg_r) + DEN_W'(lavg_r);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  rsi_div #(
    .PRICE_BITS (PRICE_BITS)
  ) u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (div_start),
    .iters       (div_iters),
    .rem_init    (div_rem),
    .dividend_lo (div_lo),
    .divisor     (div_den),
    .busy        (div_busy),
    .quotient    (div_q)
  );

  // Result when the loss average is zero
  assign rsi_special = (gavg_r == '0) ? '0 : RSI_W'(RSI_FULL);

  // Control and series state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= PERIOD_W'(PERIOD_RESET);
      have_r      <= 1'b0;
      prev_r      <= '0;
      moves_r     <= '0;
      gavg_r      <= '0;
      lavg_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (period_we) begin
        period_r <= period_wdata;
        moves_r  <= '0;
        gavg_r   <= '0;
        lavg_r   <= '0;
      end else begin
        case (op)
          OP_MOVE: begin
            prev_r <= price_r;
            if (first) begin
              have_r  <= 1'b1;
              moves_r <= '0;
              gavg_r  <= '0;
              lavg_r  <= '0;
            end
          end
          OP_ACC: begin
            gavg_r  <= gavg_r + ACC_W'(gmove);
            lavg_r  <= lavg_r + ACC_W'(lmove);
            moves_r <= moves_r + 1'b1;
          end
          OP_STORE_G: begin
            gavg_r <= div_q;
          end
          OP_STORE_L: begin
            lavg_r <= div_q;
          end
          OP_EMIT: begin
            if (!out_full) begin
              out_valid_r <= 1'b1;
            end
          end
          default: begin
            have_r <= have_r;
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    case (op)
      OP_ACCEPT: begin
        if (in_taken) begin
          price_r <= in_close_price[PW-1:0];
          start_r <= in_new_series;
        end
      end
      OP_MOVE: begin
        up_r   <= (price_r >= prev_r);
        move_r <= (price_r >= prev_r) ? price_r - prev_r : prev_r - price_r;
      end
      OP_MUL_G: begin
        mul_r <= NUM_W'(gavg_r) * NUM_W'(p_less);
      end
      OP_MUL_L: begin
        mul_r <= NUM_W'(lavg_r) * NUM_W'(p_less);
      end
      OP_MUL_RSI: begin
        mul_r <= NUM_W'(gavg_r) * NUM_W'(RSI_FULL);
      end
      OP_EMIT: begin
        if (!out_full) begin
          out_rsi_r <= (lavg_r == '0) ? rsi_special : div_q[RSI_W-1:0];
        end
      end
      default: begin
        mul_r <= mul_r;
      end
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_rsi_value = out_rsi_r;
  assign period        = period_r;

endmodule

@@ test/tb_top.sv @@
// Wilder RSI testbench: directed and random price series checked against a local RSI predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rsi_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] PERIOD_ADDR = {REG_PERIOD, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] NO_REG_ADDR = 3'd4;
  localparam int SETTLE_CYCLES  = 300;
  localparam int HOLD_CYCLES    = 3000;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [CLOSE_W-1:0] close_price;
    logic               new_series;
  } price_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               price_valid = 1'b0;
  logic [CLOSE_W-1:0] price_close = '0;
  logic               price_new = 1'b0;
  logic               rsi_ready = 1'b0;

  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  rsi_in_if  price_ch ();
  rsi_out_if rsi_ch ();

  assign price_ch.valid       = price_valid;
  assign price_ch.close_price = price_close;
  assign price_ch.new_series  = price_new;
  assign rsi_ch.ready         = rsi_ready;

  relative_strength_index dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (price_ch),
    .out_ch  (rsi_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Request queue, expected results and run bookkeeping
  price_req_t         price_reqs[$];
  price_req_t         offered;
  logic [RSI_W-1:0]   rsi_expected[$];
  logic [RSI_W-1:0]   rsi_want;
  int                 reqs_queued = 0;
  int                 reqs_accepted = 0;
  int                 error_count = 0;
  int                 send_wait = 0;
  int                 stall_left = 0;
  int                 hold_left = 0;
  int                 hold_requests = 0;
  int                 hold_served = 0;
  int                 quiet_cycles = 0;
  bit                 steady_flow = 1'b0;

  // Predictor state
  logic [PERIOD_W-1:0] period_reg = PERIOD_W'(PERIOD_RESET);
  logic [CLOSE_W-1:0]  last_close = '0;
  logic                have_last = 1'b0;
  int                  warm_moves = 0;
  logic [63:0]         gain_avg = '0;
  logic [63:0]         loss_avg = '0;

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else if (r < 98) return $urandom_range(4, 20);
    else return $urandom_range(30, 200);
  endfunction

  function automatic logic [RSI_W-1:0] rsi_from(input logic [63:0] g, input logic [63:0] l);
    logic [63:0] total;
    logic [63:0] q;
    total = g + l;
    if (total == 64'd0) q = 64'd0;
    else if (l == 64'd0) q = 64'(RSI_FULL);
    else q = (g * 64'(RSI_FULL)) / total;
    return q[RSI_W-1:0];
  endfunction

  task automatic restart_warmup();
    warm_moves = 0;
    gain_avg   = '0;
    loss_avg   = '0;
  endtask

  // Advance the RSI state by one accepted price; queue the result it yields, if any
  task automatic predict_rsi(input logic [CLOSE_W-1:0] price, input logic restart);
    logic [63:0] n;
    logic [63:0] up;
    logic [63:0] down;
    bit          produce;
    n = (period_reg == '0) ? 64'd1 : 64'(period_reg);
    produce = 1'b0;
    if (restart || !have_last) begin
      last_close = price;
      have_last  = 1'b1;
      restart_warmup();
    end else begin
      up   = (price >= last_close) ? 64'(price - last_close) : 64'd0;
      down = (price <  last_close) ? 64'(last_close - price) : 64'd0;
      last_close = price;
      if (64'(warm_moves) < n) begin
        // warm-up: plain sums, turned into averages on the closing move
        gain_avg += up;
        loss_avg += down;
        warm_moves++;
        if (64'(warm_moves) == n) begin
          gain_avg = (gain_avg << FRAC_EXTRA) / n;
          loss_avg = (loss_avg << FRAC_EXTRA) / n;
          produce  = 1'b1;
        end
      end else begin
        gain_avg = (gain_avg * (n - 64'd1) + (up << FRAC_EXTRA)) / n;
        loss_avg = (loss_avg * (n - 64'd1) + (down << FRAC_EXTRA)) / n;
        produce  = 1'b1;
      end
    end
    if (produce) rsi_expected = {rsi_expected, rsi_from(gain_avg, loss_avg)};
  endtask

  // Price driver
  always @(posedge clk) begin
    if (!rst_n) begin
      price_valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (price_ch.valid && price_ch.ready) begin
        predict_rsi(offered.close_price, offered.new_series);
        reqs_accepted++;
      end
      if (!price_valid || price_ch.ready) begin
        if (send_wait > 0) begin
          send_wait--;
          price_valid <= 1'b0;
        end else if (price_reqs.size() > 0) begin
          offered = price_reqs.pop_front();
          price_valid <= 1'b1;
          price_close <= offered.close_price;
          price_new   <= offered.new_series;
          if (!steady_flow) send_wait = pick_gap();
        end else begin
          price_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      rsi_ready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (rsi_ch.valid && rsi_ch.ready) begin
        if (rsi_expected.size() == 0) begin
          $error("rsi_value: expected none, got %0d", rsi_ch.rsi_value);
          error_count++;
        end else begin
          rsi_want = rsi_expected.pop_front();
          if (rsi_ch.rsi_value !== rsi_want) begin
            $error("rsi_value: expected %0d, got %0d", rsi_want, rsi_ch.rsi_value);
            error_count++;
          end
        end
      end
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsi_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsi_ready <= 1'b0;
      end else if (!steady_flow && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
        rsi_ready <= 1'b0;
      end else begin
        rsi_ready <= 1'b1;
      end
    end
  end

  // Watchdog: too long without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((price_ch.valid && price_ch.ready) || (rsi_ch.valid && rsi_ch.ready) ||
          (psel && penable && pready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // One APB transfer: setup phase, access phase until pready, then back to idle
  task automatic apb_cycle(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data,
                           output logic [CFG_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    logic [CFG_DATA_W-1:0] ignored;
    apb_cycle(1'b1, addr, data, ignored);
    if (addr == PERIOD_ADDR) begin
      period_reg = data[PERIOD_W-1:0];
      restart_warmup();
    end
  endtask

  task automatic check_period();
    logic [CFG_DATA_W-1:0] rd;
    apb_cycle(1'b0, PERIOD_ADDR, '0, rd);
    if (rd !== CFG_DATA_W'(period_reg)) begin
      $error("period: expected %0d, got %0d", period_reg, rd);
      error_count++;
    end
  endtask

  task automatic queue_req(input logic [CLOSE_W-1:0] price, input logic restart);
    price_req_t req;
    req.close_price = price;
    req.new_series  = restart;
    price_reqs = {price_reqs, req};
    reqs_queued++;
  endtask

  // One series: an opening price then a random walk with a chosen trend
  task automatic queue_series(input int moves, input logic fresh, input bit noisy);
    logic [CLOSE_W-1:0] price;
    logic [CLOSE_W-1:0] step;
    int                 trend;
    bit                 up;
    logic               restart;
    price = $urandom();
    trend = $urandom_range(0, 4);
    queue_req(price, fresh);
    for (int k = 0; k < moves; k++) begin
      case (trend)
        0: up = 1'b1;
        1: up = 1'b0;
        default: up = 1'($urandom_range(0, 1));
      endcase
      if (trend == 2) step = '0;
      else if (trend == 4) step = $urandom();
      else step = $urandom_range(0, 32'h0003_FFFF);
      if (up) price = (price > 32'hFFFF_FFFF - step) ? 32'hFFFF_FFFF : price + step;
      else price = (price < step) ? 32'd0 : price - step;
      // occasional broken series
      restart = noisy && ($urandom_range(0, 39) == 0);
      queue_req(price, restart);
    end
  endtask

  // Wait until every request is in and every result is out, then let the block settle
  task automatic drain();
    while (reqs_accepted != reqs_queued || rsi_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] value,
                           input int items, input bit no_idle, input bit long_hold);
    int   queued;
    int   eff;
    int   moves;
    logic fresh;
    cfg_write(addr, value);
    check_period();
    steady_flow = no_idle;
    eff = (period_reg == '0) ? 1 : int'(period_reg);
    queued = 0;
    // first series may carry on from the close kept over the period write
    fresh = 1'($urandom_range(0, 1));
    while (queued < items) begin
      if (eff > 100) moves = items - 1;
      else if ($urandom_range(0, 5) == 0) moves = $urandom_range(0, eff);
      else moves = eff + $urandom_range(0, 2 * eff + 8);
      queue_series(moves, fresh, eff <= 100);
      queued += moves + 1;
      fresh = 1'b1;
    end
    if (long_hold) hold_requests++;
    drain();
  endtask

  // Stimulus
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_period();

    // Directed: edge prices, flat, one-sided and restarted series at period 3
    cfg_write(PERIOD_ADDR, 32'd3);
    check_period();
    queue_req(32'h0000_0000, 1'b0);
    queue_req(32'hFFFF_FFFF, 1'b0);
    queue_req(32'h0000_0000, 1'b0);
    queue_req(32'hFFFF_FFFF, 1'b0);
    queue_req(32'h7FFF_0000, 1'b0);
    queue_req(32'h1234_5678, 1'b1);
    repeat (3) queue_req(32'h1234_5678, 1'b0);
    queue_req(32'h0000_1000, 1'b1);
    queue_req(32'h0000_2000, 1'b0);
    queue_req(32'h0000_3000, 1'b0);
    queue_req(32'h0000_4000, 1'b0);
    queue_req(32'h0000_5000, 1'b0);
    queue_req(32'h8000_0000, 1'b1);
    queue_req(32'h7FFF_0000, 1'b0);
    queue_req(32'h7FFE_0000, 1'b0);
    queue_req(32'h7FFD_0000, 1'b0);
    queue_req(32'h5555_AAAA, 1'b1);
    queue_req(32'hAAAA_5555, 1'b0);
    queue_req(32'h5555_AAAA, 1'b1);
    queue_req(32'h5555_AAAB, 1'b0);
    queue_req(32'h5555_AAAA, 1'b0);
    queue_req(32'h5555_AAAC, 1'b0);
    drain();

    // Random series over a range of periods
    run_phase(PERIOD_ADDR, 32'hABCD_C00E, 60, 1'b0, 1'b0);
    run_phase(PERIOD_ADDR, 32'd1, 40, 1'b1, 1'b1);
    run_phase(PERIOD_ADDR, 32'd0, 30, 1'b0, 1'b0);
    cfg_write(NO_REG_ADDR, $urandom());
    check_period();
    run_phase(PERIOD_ADDR, $urandom_range(2, 40), 50, 1'b0, 1'b0);
    run_phase(PERIOD_ADDR, 32'd1023, 1040, 1'($urandom_range(0, 1)), 1'b0);
    run_phase(PERIOD_ADDR, 32'hFFFF_FC05, 30, 1'b1, 1'b0);
    run_phase(PERIOD_ADDR, $urandom_range(2, 20), 40, 1'b0, 1'b0);

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/rsi_pkg.sv
hw/rtl/rsi_if.sv
hw/rtl/rsi_div.sv
hw/rtl/rsi_seq.sv
hw/rtl/rsi_dp.sv
hw/rtl/relative_strength_index.sv
test/tb_top.sv
